/* src/vital_sign_attention_scorer_macros.svh */
// assertion macros used by the checker
`ifndef VITAL_SIGN_ATTENTION_SCORER_MACROS_SVH
`define VITAL_SIGN_ATTENTION_SCORER_MACROS_SVH

// same-cycle implication, quiet while in reset
`define VSAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vsas check failed");

// next-cycle implication, quiet while in reset
`define VSAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vsas check failed");

// next-cycle implication that also covers reset itself
`define VSAS_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vsas reset check failed");

`endif

/* src/vsas_pkg.sv */
package vsas_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ATT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRESS_HR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REST_HR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MO_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MO_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_EN  = 3'd6;

  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_CAL    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CAL    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CLASS_LOW  = 2'd0,
    CLASS_MED  = 2'd1,
    CLASS_HIGH = 2'd2,
    CLASS_RSVD = 2'd3
  } class_t;

  typedef struct packed {
    logic [15:0] att_low;
    logic [15:0] att_high;
    logic [7:0]  stress_hr;
    logic [7:0]  rest_hr;
    logic [15:0] mo_low;
    logic [15:0] mo_high;
    logic        alert_en;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  hr;
    logic [15:0] mo;
    logic [3:0]  hr_score_fixed;
    logic [3:0]  mo_score_fixed;
    logic [3:0]  spo2_score;
    logic        hr_above;
    logic        hr_below;
  } entry_t;

  localparam logic [15:0] ATT_LOW_RST   = 16'd13107;
  localparam logic [15:0] ATT_HIGH_RST  = 16'd22938;
  localparam logic [7:0]  STRESS_HR_RST = 8'd110;
  localparam logic [7:0]  REST_HR_RST   = 8'd100;
  localparam logic [15:0] MO_LOW_RST    = 16'd410;
  localparam logic [15:0] MO_HIGH_RST   = 16'd2048;

  localparam logic [15:0] Q15_ONE      = 16'd32768;
  localparam logic [15:0] STRESS_UP    = 16'd3277;
  localparam logic [15:0] STRESS_DOWN  = 16'd1638;
  localparam logic [15:0] BASE_HR_RST  = 16'd19200;
  localparam int          AUTO_CAL_COUNT = 5;

  localparam logic [15:0] HR_NEAR   = 16'd2560;
  localparam logic [15:0] HR_MID    = 16'd5120;
  localparam logic [15:0] MO_NEAR   = 16'd410;
  localparam logic [15:0] MO_MID    = 16'd1229;
  localparam logic [6:0]  SPO2_GOOD = 7'd97;
  localparam logic [6:0]  SPO2_FAIR = 7'd95;

  // floor(z / 25) = (z * Q_RECIP) >> Q_SHIFT for z below 2^20
  localparam logic [20:0] Q_RECIP = 21'd1342178;
  localparam int          Q_SHIFT = 25;
  // floor(x / 10) = (x * D10_RECIP) >> D10_SHIFT for x below 2^20
  localparam logic [20:0] D10_RECIP = 21'd1677722;
  localparam int          D10_SHIFT = 24;

endpackage

/* src/vsas_front.sv */
module vsas_front (
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [vsas_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [1:0]                         s_tuser,
  input  vsas_pkg::cfg_t                     cfg,
  input  logic                               q_full,
  output logic                               q_push,
  output vsas_pkg::entry_t                   q_entry
);
  import vsas_pkg::*;

  logic [7:0]  hr;
  logic [6:0]  spo2;
  logic [15:0] mo;
  kind_t       kind;

  assign hr   = s_tdata[7:0];
  assign spo2 = s_tdata[14:8];
  assign mo   = s_tdata[30:15];
  assign kind = kind_t'(s_tuser);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_entry = '0;
    case (kind)
      KIND_SAMPLE: q_entry.op = OP_SAMPLE;
      KIND_CAL:    q_entry.op = OP_CAL;
      KIND_CLEAR:  q_entry.op = OP_CLEAR;
      default:     q_entry.op = OP_NONE;
    endcase
    q_entry.hr = hr;
    q_entry.mo = mo;
    q_entry.hr_score_fixed = (hr != 8'd0 && hr < cfg.stress_hr) ? 4'd8 : 4'd5;
    if (mo < cfg.mo_low) begin
      q_entry.mo_score_fixed = 4'd6;
    end else if (mo < cfg.mo_high) begin
      q_entry.mo_score_fixed = 4'd8;
    end else begin
      q_entry.mo_score_fixed = 4'd4;
    end
    if (spo2 == 7'd0) begin
      q_entry.spo2_score = 4'd5;
    end else if (spo2 >= SPO2_GOOD) begin
      q_entry.spo2_score = 4'd10;
    end else if (spo2 >= SPO2_FAIR) begin
      q_entry.spo2_score = 4'd8;
    end else begin
      q_entry.spo2_score = 4'd4;
    end
    q_entry.hr_above = hr > cfg.stress_hr;
    q_entry.hr_below = hr < cfg.rest_hr;
  end

endmodule

/* src/vsas_queue.sv */
module vsas_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vsas_pkg::entry_t din,
  output logic             full,
  input  logic             pop,
  output vsas_pkg::entry_t dout,
  output logic             empty
);
  import vsas_pkg::*;

  entry_t     slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* src/vsas_divider.sv */
module vsas_divider #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);
  localparam int DIV_W  = SUM_W + (SUM_W % 2);
  localparam int ITER   = DIV_W / 2;
  localparam int ITER_W = $clog2(ITER + 1);

  logic [DIV_W-1:0]  dvd;
  logic [DIV_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [ITER_W-1:0] cnt;
  logic              busy;
  logic [DIV_W-1:0]  dvd_next;
  logic [DIV_W-1:0]  quo_next;
  logic [CNT_W-1:0]  rem_next;

  // two restoring steps per cycle
  always_comb begin
    logic [CNT_W:0] r_sh;
    r_sh     = '0;
    dvd_next = dvd;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < 2; i++) begin
      r_sh     = {rem_next, dvd_next[DIV_W-1]};
      dvd_next = dvd_next << 1;
      if (r_sh >= {1'b0, dsr}) begin
        r_sh     = r_sh - {1'b0, dsr};
        quo_next = {quo_next[DIV_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[DIV_W-2:0], 1'b0};
      end
      rem_next = r_sh[CNT_W-1:0];
    end
  end

  assign quotient = quo[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ITER_W'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DIV_W'(dividend);
      quo <= '0;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= dvd_next;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

/* src/vsas_back.sv */
module vsas_back #(
  parameter int WINDOW_DEPTH = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  vsas_pkg::cfg_t                  cfg,
  input  logic                            q_empty,
  input  vsas_pkg::entry_t                q_head,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [vsas_pkg::OUT_DATA_W-1:0] m_tdata
);
  import vsas_pkg::*;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = $clog2(WINDOW_DEPTH * 32768 + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCORE = 7'b0000010,
    ST_WIN   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_BLEND = 7'b0010000,
    ST_BASE  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t            state;
  entry_t            ent;
  logic [15:0]       score_window [0:WINDOW_DEPTH-1];
  logic [15:0]       old_score;
  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  filled_count;
  logic [SUM_W-1:0]  window_sum;
  logic [15:0]       mean_attention;
  logic [15:0]       stress_value;
  logic              calibrated;
  logic [15:0]       base_hr;
  logic [15:0]       base_mo;
  logic              auto_cal;
  logic [40:0]       prod_q;
  logic [40:0]       prod_hr;
  logic [40:0]       prod_mo;

  logic [3:0]        hr_score;
  logic [3:0]        mo_score;
  logic [15:0]       hr_q88;
  logic [15:0]       hr_diff;
  logic [15:0]       mo_diff;
  logic [7:0]        k;
  logic [19:0]       z;
  logic [15:0]       q_score;
  logic              win_full;
  logic [CNT_W-1:0]  filled_next;
  logic [SUM_W-1:0]  sum_next;
  logic [16:0]       stress_up_sum;
  logic [15:0]       stress_next;
  logic [19:0]       x_hr;
  logic [19:0]       x_mo;
  class_t            cls;
  logic              alert;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [15:0]       div_quo;

  assign q_pop = (state == ST_IDLE) && !q_empty;

  assign hr_q88  = {ent.hr, 8'd0};
  assign hr_diff = (hr_q88 > base_hr) ? hr_q88 - base_hr : base_hr - hr_q88;
  assign mo_diff = (ent.mo > base_mo) ? ent.mo - base_mo : base_mo - ent.mo;

  always_comb begin
    if (!calibrated || ent.hr == 8'd0) begin
      hr_score = ent.hr_score_fixed;
    end else if (hr_diff < HR_NEAR) begin
      hr_score = 4'd9;
    end else if (hr_diff < HR_MID) begin
      hr_score = 4'd7;
    end else if (ent.hr_above) begin
      hr_score = 4'd3;
    end else begin
      hr_score = 4'd5;
    end
    if (!calibrated) begin
      mo_score = ent.mo_score_fixed;
    end else if (mo_diff < MO_NEAR) begin
      mo_score = 4'd9;
    end else if (mo_diff < MO_MID) begin
      mo_score = 4'd7;
    end else begin
      mo_score = 4'd4;
    end
  end

  // weighted score in units of 1/200, then Q1.15 rounded half up
  assign k = 8'(32'(hr_score) * 8 + 32'(mo_score) * 7 + 32'(ent.spo2_score) * 5);
  assign z = {k, 12'd0} + 20'd12;
  assign q_score = prod_q[Q_SHIFT+15:Q_SHIFT];

  assign win_full    = filled_count == CNT_W'(WINDOW_DEPTH);
  assign filled_next = win_full ? filled_count : filled_count + 1'b1;
  assign sum_next    = window_sum - (win_full ? SUM_W'(old_score) : '0) + SUM_W'(q_score);

  assign stress_up_sum = {1'b0, stress_value} + {1'b0, STRESS_UP};
  always_comb begin
    if (ent.hr_above) begin
      stress_next = (stress_up_sum > {1'b0, Q15_ONE}) ? Q15_ONE : stress_up_sum[15:0];
    end else if (ent.hr_below) begin
      stress_next = (stress_value > STRESS_DOWN) ? stress_value - STRESS_DOWN : 16'd0;
    end else begin
      stress_next = stress_value;
    end
  end

  assign x_hr = 20'(32'(base_hr) * 7 + 32'(ent.hr) * 768 + 5);
  assign x_mo = 20'(32'(base_mo) * 7 + 32'(ent.mo) * 3 + 5);

  always_comb begin
    if (mean_attention < cfg.att_low) begin
      cls = CLASS_LOW;
    end else if (mean_attention < cfg.att_high) begin
      cls = CLASS_MED;
    end else begin
      cls = CLASS_HIGH;
    end
  end

  assign alert     = (ent.op == OP_SAMPLE) && cfg.alert_en && (cls == CLASS_LOW);
  assign out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign div_start = state == ST_WIN;

  vsas_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (filled_next),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      write_slot     <= '0;
      filled_count   <= '0;
      window_sum     <= '0;
      mean_attention <= Q15_ONE;
      stress_value   <= 16'd0;
      calibrated     <= 1'b0;
      base_hr        <= BASE_HR_RST;
      base_mo        <= 16'd0;
      auto_cal       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_SCORE;
          end
        end
        ST_SCORE: begin
          case (ent.op)
            OP_SAMPLE: state <= ST_WIN;
            OP_CAL:    state <= ST_BLEND;
            OP_CLEAR: begin
              write_slot   <= '0;
              filled_count <= '0;
              window_sum   <= '0;
              calibrated   <= 1'b0;
              state        <= ST_OUT;
            end
            default:   state <= ST_OUT;
          endcase
        end
        ST_WIN: begin
          filled_count <= filled_next;
          window_sum   <= sum_next;
          write_slot   <= (write_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
          stress_value <= stress_next;
          auto_cal     <= (32'(filled_next) > AUTO_CAL_COUNT) && !calibrated;
          state        <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            mean_attention <= div_quo;
            state          <= auto_cal ? ST_BLEND : ST_OUT;
          end
        end
        ST_BLEND: begin
          state <= ST_BASE;
        end
        ST_BASE: begin
          base_hr    <= prod_hr[D10_SHIFT+15:D10_SHIFT];
          base_mo    <= prod_mo[D10_SHIFT+15:D10_SHIFT];
          calibrated <= 1'b1;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent <= q_head;
    end
    if (state == ST_SCORE) begin
      prod_q    <= 41'(z) * 41'(Q_RECIP);
      old_score <= score_window[write_slot];
    end
    if (state == ST_WIN) begin
      score_window[write_slot] <= q_score;
    end
    if (state == ST_BLEND) begin
      prod_hr <= 41'(x_hr) * 41'(D10_RECIP);
      prod_mo <= 41'(x_mo) * 41'(D10_RECIP);
    end
    if (out_load) begin
      m_tdata <= {4'd0, alert, calibrated, stress_value, cls, mean_attention};
    end
  end

endmodule

/* src/vital_sign_attention_scorer.sv */
// flow: a sample passes score, window update and the window mean divider, which takes
// two quotient bits a cycle, then blend and base when it calibrates, then output
// a calibrate item passes score, blend and base; a clear or unused item goes from score to output
// one item at a time through the back end, a new item taken only from idle; two-entry queue
// reset: synchronous, active high; clears control state, registers to defaults
module vital_sign_attention_scorer #(
  parameter int WINDOW_DEPTH = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // heart_rate, oxygen_saturation, motion_level
  input  logic [vsas_pkg::IN_DATA_W-1:0]      s_tdata,
  // kind
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // attention_level, attention_class, stress_level, is_calibrated, alert_request
  output logic [vsas_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_wr_en,
  input  logic [vsas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vsas_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vsas_pkg::*;

  cfg_t   cfg;
  entry_t q_entry;
  entry_t q_head;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.att_low   <= ATT_LOW_RST;
      cfg.att_high  <= ATT_HIGH_RST;
      cfg.stress_hr <= STRESS_HR_RST;
      cfg.rest_hr   <= REST_HR_RST;
      cfg.mo_low    <= MO_LOW_RST;
      cfg.mo_high   <= MO_HIGH_RST;
      cfg.alert_en  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ATT_LOW:   cfg.att_low   <= cfg_data;
        REG_ATT_HIGH:  cfg.att_high  <= cfg_data;
        REG_STRESS_HR: cfg.stress_hr <= cfg_data[7:0];
        REG_REST_HR:   cfg.rest_hr   <= cfg_data[7:0];
        REG_MO_LOW:    cfg.mo_low    <= cfg_data;
        REG_MO_HIGH:   cfg.mo_high   <= cfg_data;
        REG_ALERT_EN:  cfg.alert_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vsas_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  vsas_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_entry),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  vsas_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* src/vsas_checker.sv */
`include "vital_sign_attention_scorer_macros.svh"

module vsas_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [vsas_pkg::OUT_DATA_W-1:0] m_tdata
);
  import vsas_pkg::*;

  `VSAS_ASSERT_RESET(a_reset_quiet, rst, !m_tvalid)
  `VSAS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `VSAS_ASSERT_NOW(a_class_code, m_tvalid, m_tdata[17:16] != CLASS_RSVD)
  `VSAS_ASSERT_NOW(a_alert_low, m_tvalid && m_tdata[35], m_tdata[17:16] == CLASS_LOW)
  `VSAS_ASSERT_NOW(a_q15_range, m_tvalid, m_tdata[15:0] <= Q15_ONE && m_tdata[33:18] <= Q15_ONE)

endmodule

bind vital_sign_attention_scorer vsas_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import vsas_pkg::*;

  localparam int WINDOW_DEPTH = 20;

  typedef struct {
    kind_t       kind;
    logic [7:0]  hr;
    logic [6:0]  spo2;
    logic [15:0] motion;
  } vitals_t;

  typedef struct {
    logic [15:0] attention;
    class_t      cls;
    logic [15:0] stress;
    logic        calibrated;
    logic        alert;
  } status_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PATTERN,
    RDY_SPARSE
  } ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vital_sign_attention_scorer #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // scorer state as the block should hold it
  cfg_t        limits;
  logic [15:0] score_hist [WINDOW_DEPTH];
  logic [4:0]  slot;
  logic [4:0]  filled;
  logic [20:0] score_sum;
  logic [15:0] mean_att;
  logic [15:0] stress;
  logic        calibrated;
  logic [15:0] base_hr;
  logic [15:0] base_mo;

  vitals_t     pending[$];
  status_t     expected_status[$];
  vitals_t     on_bus;
  status_t     want;
  int          burst_left = 0;
  int          gap_left = 0;
  int          kinds_sent[4] = '{0, 0, 0, 0};
  int          n_checked = 0;
  int          n_alerts = 0;
  int          n_errors = 0;
  int unsigned ready_tick = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;

  function automatic int unsigned heart_tenths(logic [7:0] hr);
    int unsigned hq;
    int unsigned d;
    if (hr == 0 || !calibrated) return (hr != 0 && hr < limits.stress_hr) ? 8 : 5;
    hq = {hr, 8'h00};
    d = hq > base_hr ? hq - base_hr : base_hr - hq;
    if (d < HR_NEAR) return 9;
    if (d < HR_MID) return 7;
    if (hr > limits.stress_hr) return 3;
    return 5;
  endfunction

  function automatic int unsigned motion_tenths(logic [15:0] mo);
    int unsigned d;
    if (!calibrated) begin
      if (mo < limits.mo_low) return 6;
      if (mo < limits.mo_high) return 8;
      return 4;
    end
    d = mo > base_mo ? mo - base_mo : base_mo - mo;
    if (d < MO_NEAR) return 9;
    if (d < MO_MID) return 7;
    return 4;
  endfunction

  function automatic int unsigned spo2_tenths(logic [6:0] sp);
    if (sp == 0) return 5;
    if (sp >= SPO2_GOOD) return 10;
    if (sp >= SPO2_FAIR) return 8;
    return 4;
  endfunction

  function automatic void blend_baselines(logic [7:0] hr, logic [15:0] mo);
    base_hr = 16'((7 * 32'(base_hr) + 768 * 32'(hr) + 5) / 10);
    base_mo = 16'((7 * 32'(base_mo) + 3 * 32'(mo) + 5) / 10);
    calibrated = 1'b1;
  endfunction

  function automatic class_t attention_class();
    if (mean_att < limits.att_low) return CLASS_LOW;
    if (mean_att < limits.att_high) return CLASS_MED;
    return CLASS_HIGH;
  endfunction

  function automatic status_t score_item(vitals_t v);
    status_t     r;
    int unsigned raw;
    int unsigned q;
    r.alert = 1'b0;
    case (v.kind)
      KIND_SAMPLE: begin
        raw = heart_tenths(v.hr) * 40 + motion_tenths(v.motion) * 35
            + spo2_tenths(v.spo2) * 25;
        q = (raw * 32768 + 500) / 1000;
        if (filled < WINDOW_DEPTH) filled = filled + 1'b1;
        else score_sum = score_sum - score_hist[slot];
        score_hist[slot] = q[15:0];
        score_sum = score_sum + q[15:0];
        slot = (slot == WINDOW_DEPTH - 1) ? '0 : slot + 1'b1;
        mean_att = 16'(32'(score_sum) / 32'(filled));
        if (v.hr > limits.stress_hr) begin
          if (32'(stress) + STRESS_UP > Q15_ONE) stress = Q15_ONE;
          else stress = stress + STRESS_UP;
        end else if (v.hr < limits.rest_hr) begin
          stress = stress > STRESS_DOWN ? stress - STRESS_DOWN : '0;
        end
        if (filled > AUTO_CAL_COUNT && !calibrated) blend_baselines(v.hr, v.motion);
        r.alert = limits.alert_en && attention_class() == CLASS_LOW;
      end
      KIND_CAL: begin
        blend_baselines(v.hr, v.motion);
      end
      KIND_CLEAR: begin
        slot = '0;
        filled = '0;
        score_sum = '0;
        calibrated = 1'b0;
      end
      default: begin
      end
    endcase
    r.attention = mean_att;
    r.cls = attention_class();
    r.stress = stress;
    r.calibrated = calibrated;
    return r;
  endfunction

  function automatic vitals_t vitals(kind_t k, logic [7:0] hr, logic [6:0] sp,
                                     logic [15:0] mo);
    vitals_t v;
    v.kind = k;
    v.hr = hr;
    v.spo2 = sp;
    v.motion = mo;
    return v;
  endfunction

  function automatic vitals_t random_vitals();
    vitals_t     v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) v.kind = KIND_CLEAR;
    else if (pick < 9) v.kind = KIND_CAL;
    else if (pick < 11) v.kind = KIND_NONE;
    else v.kind = KIND_SAMPLE;
    if ($urandom_range(0, 9) == 0) begin
      // full-range noise
      v.hr = 8'($urandom);
      v.spo2 = 7'($urandom);
      v.motion = 16'($urandom);
    end else begin
      v.hr = ($urandom_range(0, 29) == 0) ? 8'd0 : 8'($urandom_range(55, 135));
      v.spo2 = ($urandom_range(0, 29) == 0) ? 7'd0 : 7'($urandom_range(88, 100));
      v.motion = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4095))
                                             : 16'($urandom_range(0, 1500));
    end
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ATT_LOW:   limits.att_low = val;
      REG_ATT_HIGH:  limits.att_high = val;
      REG_STRESS_HR: limits.stress_hr = val[7:0];
      REG_REST_HR:   limits.rest_hr = val[7:0];
      REG_MO_LOW:    limits.mo_low = val;
      REG_MO_HIGH:   limits.mo_high = val;
      REG_ALERT_EN:  limits.alert_en = val[0];
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_limits(logic [15:0] att_low, logic [15:0] att_high,
                                logic [7:0] stress_hr, logic [7:0] rest_hr,
                                logic [15:0] mo_low, logic [15:0] mo_high, logic alert_en);
    write_reg(REG_ATT_LOW, att_low);
    write_reg(REG_ATT_HIGH, att_high);
    write_reg(REG_STRESS_HR, {8'h00, stress_hr});
    write_reg(REG_REST_HR, {8'h00, rest_hr});
    write_reg(REG_MO_LOW, mo_low);
    write_reg(REG_MO_HIGH, mo_high);
    write_reg(REG_ALERT_EN, {15'h0000, alert_en});
  endtask

  // sender stops once its queue runs dry, then the block drains
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || s_tvalid || expected_status.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pending.push_back(random_vitals());
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_status.push_back(score_item(on_bus));
        kinds_sent[on_bus.kind]++;
      end
      if (gap_left > 0 || pending.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        on_bus = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, on_bus.motion, on_bus.spo2, on_bus.hr};
        s_tuser <= on_bus.kind;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    ready_tick++;
    if (ready_tick % 256 == 0) ready_mode = ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS:  m_tready <= 1'b1;
      RDY_COIN:    m_tready <= 1'($urandom_range(0, 1));
      RDY_PATTERN: m_tready <= (ready_tick % 7) != 3;
      default:     m_tready <= (ready_tick % 32) < 6;
    endcase
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_status.size() == 0) begin
        $error("result beat with nothing expected: %h", m_tdata);
        n_errors++;
      end else begin
        want = expected_status.pop_front();
        n_checked++;
        if (m_tdata[35]) n_alerts++;
        if (m_tdata[15:0] !== want.attention) begin
          $error("attention_level: expected %0d, got %0d", want.attention, m_tdata[15:0]);
          n_errors++;
        end
        if (m_tdata[17:16] !== want.cls) begin
          $error("attention_class: expected %0d, got %0d", want.cls, m_tdata[17:16]);
          n_errors++;
        end
        if (m_tdata[33:18] !== want.stress) begin
          $error("stress_level: expected %0d, got %0d", want.stress, m_tdata[33:18]);
          n_errors++;
        end
        if (m_tdata[34] !== want.calibrated) begin
          $error("is_calibrated: expected %0d, got %0d", want.calibrated, m_tdata[34]);
          n_errors++;
        end
        if (m_tdata[35] !== want.alert) begin
          $error("alert_request: expected %0d, got %0d", want.alert, m_tdata[35]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    logic [15:0] lo;
    limits.att_low = ATT_LOW_RST;
    limits.att_high = ATT_HIGH_RST;
    limits.stress_hr = STRESS_HR_RST;
    limits.rest_hr = REST_HR_RST;
    limits.mo_low = MO_LOW_RST;
    limits.mo_high = MO_HIGH_RST;
    limits.alert_en = 1'b1;
    slot = '0;
    filled = '0;
    score_sum = '0;
    mean_att = Q15_ONE;
    stress = '0;
    calibrated = 1'b0;
    base_hr = BASE_HR_RST;
    base_mo = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: boundaries, auto calibration, clear, unused kind
    pending.push_back(vitals(KIND_NONE, 8'd0, 7'd0, 16'd0));
    pending.push_back(vitals(KIND_SAMPLE, 8'd0, 7'd0, 16'd0));
    pending.push_back(vitals(KIND_SAMPLE, 8'd255, 7'd127, 16'hFFFF));
    pending.push_back(vitals(KIND_SAMPLE, 8'd90, 7'd98, 16'd300));
    pending.push_back(vitals(KIND_SAMPLE, 8'd109, 7'd96, 16'd409));
    pending.push_back(vitals(KIND_SAMPLE, 8'd110, 7'd95, 16'd410));
    pending.push_back(vitals(KIND_SAMPLE, 8'd111, 7'd94, 16'd2047));
    pending.push_back(vitals(KIND_SAMPLE, 8'd100, 7'd97, 16'd2048));
    pending.push_back(vitals(KIND_SAMPLE, 8'd80, 7'd99, 16'd500));
    pending.push_back(vitals(KIND_SAMPLE, 8'd0, 7'd100, 16'd0));
    pending.push_back(vitals(KIND_CAL, 8'd72, 7'd0, 16'd800));
    pending.push_back(vitals(KIND_SAMPLE, 8'd72, 7'd97, 16'd800));
    pending.push_back(vitals(KIND_SAMPLE, 8'd88, 7'd96, 16'd1500));
    pending.push_back(vitals(KIND_SAMPLE, 8'd130, 7'd90, 16'd3000));
    pending.push_back(vitals(KIND_SAMPLE, 8'd95, 7'd93, 16'd1200));
    pending.push_back(vitals(KIND_CLEAR, 8'd0, 7'd0, 16'd0));
    pending.push_back(vitals(KIND_NONE, 8'd255, 7'd127, 16'hFFFF));
    pending.push_back(vitals(KIND_CAL, 8'd255, 7'd127, 16'hFFFF));
    pending.push_back(vitals(KIND_SAMPLE, 8'd60, 7'd99, 16'd100));
    pending.push_back(vitals(KIND_CLEAR, 8'd255, 7'd127, 16'hFFFF));
    pending.push_back(vitals(KIND_SAMPLE, 8'd105, 7'd1, 16'd1));
    pending.push_back(vitals(KIND_SAMPLE, 8'd99, 7'd96, 16'd2049));
    pending.push_back(vitals(KIND_SAMPLE, 8'd1, 7'd127, 16'h8000));
    pending.push_back(vitals(KIND_SAMPLE, 8'd128, 7'd64, 16'h7FFF));
    wait_idle();

    program_limits(16'd9830, 16'd26214, 8'd120, 8'd90, 16'd200, 16'd3000, 1'b1);
    queue_random(150);
    wait_idle();

    program_limits(16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0);
    queue_random(100);
    wait_idle();

    program_limits(Q15_ONE, Q15_ONE, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_random(100);
    wait_idle();

    repeat (4) begin
      lo = 16'($urandom_range(0, 32768));
      program_limits(lo, 16'($urandom_range(lo, 32768)), 8'($urandom_range(90, 140)),
                     8'($urandom_range(60, 120)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 6000)), 1'($urandom_range(0, 1)));
      queue_random(95);
      wait_idle();
    end

    $display("beats sent: %0d samples, %0d calibrate, %0d clear, %0d unused; 8 limit settings",
             kinds_sent[KIND_SAMPLE], kinds_sent[KIND_CAL], kinds_sent[KIND_CLEAR],
             kinds_sent[KIND_NONE]);
    $display("result beats checked: %0d, alerts seen: %0d", n_checked, n_alerts);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
